// File: rtl/core/tssl_pkg.sv
// shared types and constants for the timer schedule sorted list
`timescale 1ns / 1ps

package tssl_pkg;

   localparam int LIST_ENTRIES_DEFAULT = 16;
   localparam int KEY_WIDTH            = 42;
   localparam int ENTRY_WIDTH          = KEY_WIDTH + 4 + 1;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_TOGGLE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BEYOND   = 2'd2,
      STATUS_INACTIVE = 2'd3
   } status_type;

   typedef struct packed {
      op_type      operation;
      logic [3:0]  slot_index;
      logic        slot_active;
      logic [15:0] wake_year;
      logic [3:0]  wake_month;
      logic [4:0]  wake_day;
      logic [16:0] wake_seconds;
      logic [3:0]  position;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  where_placed;
      logic [3:0]  stored_slot;
      logic        keep_mark;
      logic [4:0]  entry_count;
      logic        any_unmarked;
   } rsp_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] sort_key;
      logic [3:0]           slot;
      logic                 mark;
   } entry_type;

endpackage

// File: rtl/core/tssl_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tssl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/timer_schedule_sorted_list.sv
// top level: wake-up ordered timer slot list with ram-based insertion sequencer
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; its result appears on
// rsp_data with rsp_strobe, which is high for exactly one cycle, the cycle after the command
// finishes, and cannot be held off. Clear, inactive or full inserts and
// out-of-range toggles or reads finish in the accept cycle. An in-range read or
// toggle reads the ram, then for a toggle modifies and writes back the entry.
// An insert moves the entries behind its landing position up by one, one per
// cycle, through the single read and write port of the entry ram, each read
// compared against the new key the cycle after it is issued.
// The ram needs no clearing after reset.
module timer_schedule_sorted_list
   import tssl_pkg::*;
#(
   parameter int LIST_ENTRIES = LIST_ENTRIES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IW   = $clog2(LIST_ENTRIES);
   localparam int CW   = $clog2(LIST_ENTRIES + 1);
   localparam int CMPW = (CW > 4) ? CW : 4;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SHIFT  = 4'b0010,
      ST_PLACE  = 4'b0100,
      ST_ACCESS = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [CW-1:0]     unmark_ff, unmark_in;
   logic [IW-1:0]     p_ff, p_in;
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   logic              ram_we, ram_re;
   logic [IW-1:0]     ram_waddr, ram_raddr;
   entry_type         ram_wdata, rd_entry, new_entry;
   logic [ENTRY_WIDTH-1:0] ram_rdata;

   assign rd_entry  = entry_type'(ram_rdata);
   assign new_entry = '{sort_key: {req_ff.wake_year, req_ff.wake_month,
                                   req_ff.wake_day, req_ff.wake_seconds},
                        slot: req_ff.slot_index, mark: 1'b1};

   tssl_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (LIST_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      unmark_in     = unmark_ff;
      p_in          = p_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = p_ff;
      ram_wdata     = new_entry;
      ram_re        = 1'b0;
      ram_raddr     = p_ff - 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in              = req_data;
               rsp_in.status       = STATUS_OK;
               rsp_in.where_placed = '0;
               rsp_in.stored_slot  = '0;
               rsp_in.keep_mark    = 1'b0;
               case (req_data.operation)
                  OP_CLEAR: begin
                     len_in        = '0;
                     unmark_in     = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  OP_INSERT: begin
                     if (!req_data.slot_active) begin
                        rsp_in.status = STATUS_INACTIVE;
                        rsp_strobe_in = 1'b1;
                     end else if (len_ff == CW'(LIST_ENTRIES)) begin
                        rsp_in.status = STATUS_FULL;
                        rsp_strobe_in = 1'b1;
                     end else if (len_ff == '0) begin
                        p_in     = '0;
                        state_in = ST_PLACE;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = IW'(len_ff - 1'b1);
                        p_in      = IW'(len_ff);
                        state_in  = ST_SHIFT;
                     end
                  end
                  default: begin
                     rsp_in.where_placed = req_data.position;
                     if (CMPW'(req_data.position) >= CMPW'(len_ff)) begin
                        rsp_in.status = STATUS_BEYOND;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = IW'(req_data.position);
                        p_in      = IW'(req_data.position);
                        state_in  = ST_ACCESS;
                     end
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (new_entry.sort_key > rd_entry.sort_key) begin
               state_in = ST_PLACE;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = p_ff;
               ram_wdata = rd_entry;
               p_in      = p_ff - 1'b1;
               if (p_ff == IW'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = p_ff - IW'(2);
               end
            end
         end
         ST_PLACE: begin
            ram_we              = 1'b1;
            ram_waddr           = p_ff;
            ram_wdata           = new_entry;
            len_in              = len_ff + 1'b1;
            rsp_in.status       = STATUS_OK;
            rsp_in.where_placed = 4'(p_ff);
            rsp_in.stored_slot  = req_ff.slot_index;
            rsp_in.keep_mark    = 1'b1;
            rsp_strobe_in       = 1'b1;
            state_in            = ST_IDLE;
         end
         ST_ACCESS: begin
            rsp_in.status       = STATUS_OK;
            rsp_in.where_placed = 4'(p_ff);
            rsp_in.stored_slot  = rd_entry.slot;
            rsp_in.keep_mark    = rd_entry.mark;
            if (req_ff.operation == OP_TOGGLE) begin
               ram_we           = 1'b1;
               ram_waddr        = p_ff;
               ram_wdata        = '{sort_key: rd_entry.sort_key, slot: rd_entry.slot,
                                    mark: !rd_entry.mark};
               rsp_in.keep_mark = !rd_entry.mark;
               unmark_in        = rd_entry.mark ? unmark_ff + 1'b1 : unmark_ff - 1'b1;
            end
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_strobe_in) begin
         rsp_in.entry_count  = 5'(len_in);
         rsp_in.any_unmarked = (unmark_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         unmark_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         unmark_ff     <= unmark_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CW'(LIST_ENTRIES))
      else $error("entry count beyond capacity");

   a_unmark_bound: assert property (@(posedge clock) disable iff (reset)
      unmark_ff <= len_ff)
      else $error("unmarked count exceeds entry count");

   a_shift_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (p_ff != '0) && (CW'(p_ff) <= len_ff))
      else $error("shift position out of list");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != ST_IDLE))
      else $error("ram write while idle");

   a_strobe_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_IDLE))
      else $error("result shown while a command is still running");

endmodule
